### hw/rtl/uer_pkg.sv
`default_nettype none

package uer_pkg;

    // free-running time-stamp counter width
    localparam int CNT_BITS = 16;

    // field widths
    localparam int PHASE_CNT_W = 8;
    localparam int WAIT_W      = 16;
    localparam int PULSE_W     = 16;
    localparam int FACTOR_W    = 16;
    localparam int DIST_W      = 19;
    localparam int PROD_W      = PULSE_W + FACTOR_W;
    localparam int FRAC_SHIFT  = 8;
    localparam int SCALED_W    = PROD_W - FRAC_SHIFT;

    // stream and configuration port widths
    localparam int S_DATA_W    = 8;
    localparam int M_FIELDS_W  = 4 + PULSE_W + DIST_W;
    localparam int M_DATA_W    = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TRIG_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRIG_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FACTOR    = 2'd3;

    // register reset values
    localparam logic [7:0]          TRIG_LOW_RST  = 8'd2;
    localparam logic [7:0]          TRIG_HIGH_RST = 8'd10;
    localparam logic [WAIT_W-1:0]   TIMEOUT_RST   = 16'd30000;
    localparam logic [FACTOR_W-1:0] FACTOR_RST    = 16'd1114;

    // saturation limit of the distance
    localparam logic [DIST_W-1:0]   DIST_MAX      = {DIST_W{1'b1}};

    // status codes
    localparam logic STATUS_MEASURED = 1'b0;
    localparam logic STATUS_TIMEOUT  = 1'b1;

    typedef struct packed {
        logic [7:0]          trig_low_ticks;
        logic [7:0]          trig_high_ticks;
        logic [WAIT_W-1:0]   timeout_ticks;
        logic [FACTOR_W-1:0] cm_per_tick_q16;
    } cfg_t;

    typedef struct packed {
        logic [DIST_W-1:0]  distance_q8;
        logic [PULSE_W-1:0] pulse_ticks;
        logic               status;
        logic               result_valid;
        logic               busy_res;
        logic               trig_level;
    } res_t;

endpackage

`default_nettype wire

### hw/rtl/ultrasonic_echo_ranger_top.sv
`default_nettype none

// Ultrasonic echo ranger. Feed one transaction per microsecond tick on the slave
// stream; each one gives exactly one result transaction on the master stream,
// registered in the output register. Ticks are taken back to back at
// one per clock, held only while the output register is full and not being
// taken. A start request while idle drives the trigger low, then high, for the
// configured tick counts, then time-stamps the echo's rising and falling edges
// on a free-running 16-bit counter; the width (modulo 2^16) is scaled by the
// Q0.16 factor to a distance in 1/256 cm, saturated at 524287. If the echo is not
// complete within timeout_ticks ticks of the trigger ending, the result carries
// status timeout with zero width and distance. Registers are written with cfg_we,
// cfg_index, cfg_wdata; the user keeps the stream quiet, the block does not check.
module ultrasonic_echo_ranger_top
    import uer_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // start_req [0], echo_level [1], zero [7:2]
    input  wire logic [S_DATA_W-1:0]   s_tdata,

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // trig_level [0], busy_res [1], result_valid [2], status [3],
    // pulse_ticks [19:4], distance_q8 [38:20], zero [39]
    output logic [M_DATA_W-1:0]        m_tdata,

    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t                cfg_reg;
    res_t                res;
    logic                step_en;
    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    // configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trig_low_ticks  <= TRIG_LOW_RST;
            cfg_reg.trig_high_ticks <= TRIG_HIGH_RST;
            cfg_reg.timeout_ticks   <= TIMEOUT_RST;
            cfg_reg.cm_per_tick_q16 <= FACTOR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TRIG_LOW:  cfg_reg.trig_low_ticks  <= cfg_wdata[7:0];
                REG_TRIG_HIGH: cfg_reg.trig_high_ticks <= cfg_wdata[7:0];
                REG_TIMEOUT:   cfg_reg.timeout_ticks   <= cfg_wdata[WAIT_W-1:0];
                REG_FACTOR:    cfg_reg.cm_per_tick_q16 <= cfg_wdata[FACTOR_W-1:0];
                default:       cfg_reg.trig_low_ticks  <= cfg_reg.trig_low_ticks;
            endcase
        end
    end

    // a tick is taken whenever the output register is free or being emptied
    assign s_tready = !m_tvalid_reg || m_tready;
    assign step_en  = s_tvalid && s_tready;

    uer_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (step_en),
        .start_req  (s_tdata[0]),
        .echo_level (s_tdata[1]),
        .cfg        (cfg_reg),
        .res        (res)
    );

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (step_en)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            m_tdata_reg <= M_DATA_W'(res);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

### hw/rtl/uer_core.sv
`default_nettype none

module uer_core
    import uer_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic step_en,
    input  wire logic start_req,
    input  wire logic echo_level,
    input  wire cfg_t cfg,
    output res_t      res
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LOW,
        PH_HIGH,
        PH_RISE,
        PH_FALL
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [PHASE_CNT_W-1:0] phase_cnt_reg, phase_cnt_next;
    logic [CNT_BITS-1:0]    free_cnt_reg;
    logic [CNT_BITS-1:0]    rise_stamp_reg, rise_stamp_next;
    logic [WAIT_W-1:0]      wait_cnt_reg, wait_cnt_next;
    logic                   echo_prev_reg;

    logic                   rise, fall;
    logic [CNT_BITS-1:0]    width;
    logic [31:0]            width_ext;
    logic [PULSE_W-1:0]     width_lo;
    logic [PROD_W-1:0]      prod;
    logic [SCALED_W-1:0]    scaled;
    logic [DIST_W-1:0]      dist_sat;

    // edge detection against the previous tick's sample
    assign rise = echo_level && !echo_prev_reg;
    assign fall = !echo_level && echo_prev_reg;

    // echo width and its scaling to distance
    assign width     = free_cnt_reg - rise_stamp_reg;
    assign width_ext = 32'(width);
    assign width_lo  = width_ext[PULSE_W-1:0];
    assign prod      = PROD_W'(width_lo) * PROD_W'(cfg.cm_per_tick_q16);
    assign scaled    = prod[PROD_W-1:FRAC_SHIFT];
    assign dist_sat  = (scaled > SCALED_W'(DIST_MAX)) ? DIST_MAX : scaled[DIST_W-1:0];

    // one tick of the measurement sequence; phases may chain within a tick
    always_comb
    begin
        logic done;
        done            = 1'b0;
        phase_next      = phase_reg;
        phase_cnt_next  = phase_cnt_reg;
        rise_stamp_next = rise_stamp_reg;
        wait_cnt_next   = wait_cnt_reg;
        res             = '0;

        if (phase_next == PH_IDLE && start_req)
        begin
            phase_next     = PH_LOW;
            phase_cnt_next = '0;
        end

        if (phase_next == PH_LOW)
        begin
            if (phase_cnt_next < cfg.trig_low_ticks)
            begin
                phase_cnt_next = phase_cnt_next + 8'd1;
            end
            else
            begin
                phase_next     = PH_HIGH;
                phase_cnt_next = '0;
            end
        end

        if (phase_next == PH_HIGH)
        begin
            if (phase_cnt_next < cfg.trig_high_ticks)
            begin
                res.trig_level = 1'b1;
                phase_cnt_next = phase_cnt_next + 8'd1;
            end
            else
            begin
                phase_next     = PH_RISE;
                phase_cnt_next = '0;
                wait_cnt_next  = '0;
            end
        end

        if (phase_next == PH_RISE || phase_next == PH_FALL)
        begin
            if (phase_next == PH_RISE && rise)
            begin
                rise_stamp_next = free_cnt_reg;
                phase_next      = PH_FALL;
            end
            else if (phase_next == PH_FALL && fall)
            begin
                res.pulse_ticks  = width_lo;
                res.distance_q8  = dist_sat;
                res.result_valid = 1'b1;
                res.status       = STATUS_MEASURED;
                done             = 1'b1;
                phase_next       = PH_IDLE;
            end

            // timeout covers rise and fall together
            if (!done)
            begin
                wait_cnt_next = wait_cnt_next + 16'd1;
                if (wait_cnt_next >= cfg.timeout_ticks)
                begin
                    res.result_valid = 1'b1;
                    res.status       = STATUS_TIMEOUT;
                    res.pulse_ticks  = '0;
                    res.distance_q8  = '0;
                    phase_next       = PH_IDLE;
                end
            end
        end

        res.busy_res = (phase_next != PH_IDLE);
    end

    // sequence state, advanced once per accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            phase_cnt_reg  <= '0;
            free_cnt_reg   <= '0;
            rise_stamp_reg <= '0;
            wait_cnt_reg   <= '0;
            echo_prev_reg  <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg      <= phase_next;
            phase_cnt_reg  <= phase_cnt_next;
            free_cnt_reg   <= free_cnt_reg + CNT_BITS'(1);
            rise_stamp_reg <= rise_stamp_next;
            wait_cnt_reg   <= wait_cnt_next;
            echo_prev_reg  <= echo_level;
        end
    end

    // a finished measurement returns the sequencer to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        rst_n && step_en && res.result_valid |=> phase_reg == PH_IDLE)
    else $error("sequencer not idle after a result");

    // the time-stamp counter moves exactly once per tick
    assert property (@(posedge clk) disable iff (!rst_n)
        rst_n && step_en |=> free_cnt_reg == $past(free_cnt_reg) + CNT_BITS'(1))
    else $error("time-stamp counter skipped or stalled");

    // a held stream must not disturb the sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        rst_n && !step_en |=> $stable(phase_reg) && $stable(wait_cnt_reg))
    else $error("sequence advanced without a transaction");

    // a timeout carries no width and no distance
    assert property (@(posedge clk) disable iff (!rst_n)
        res.result_valid && res.status == STATUS_TIMEOUT
        |-> res.pulse_ticks == '0 && res.distance_q8 == '0)
    else $error("timeout result carries a width");

    // trigger is only driven high inside a measurement
    assert property (@(posedge clk) disable iff (!rst_n)
        res.trig_level |-> res.busy_res && !res.result_valid)
    else $error("trigger high outside a measurement");

endmodule

`default_nettype wire
